@@ rtl/core/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer: command
// codes, datapath command and status groups, default widths.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int RadiusBitsDef = 11;
  localparam int CoordBitsDef  = 16;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  typedef enum logic [2:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_X_XP1,
    MUL_YM_YM,
    MUL_RY2_TA,
    MUL_RX2_TB,
    MUL_RX2_RY2
  } mul_sel_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_LOAD,
    WB_RX2,
    WB_RY2,
    WB_START,
    WB_TA,
    WB_TB,
    WB_ACC_SET,
    WB_ACC_ADD,
    WB_ACC_SUB,
    WB_SWITCH,
    WB_EMIT,
    WB_DECIDE
  } wb_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic switch_due;
  } dp_status_t;

endpackage

@@ rtl/core/mer_datapath.sv @@
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse walk state, shared multiplier with registered product, decision
// arithmetic and the registered output group.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int RADIUS_BITS = mer_pkg::RadiusBitsDef,
  parameter int COORD_BITS  = mer_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mer_pkg::dp_cmd_t              cmd_i,
  output mer_pkg::dp_status_t           status_o,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_x_i,
  input  logic        [RADIUS_BITS-1:0] radius_y_i,
  output logic signed [COORD_BITS:0]    right_lower_x_o,
  output logic signed [COORD_BITS:0]    right_lower_y_o,
  output logic signed [COORD_BITS:0]    left_lower_x_o,
  output logic signed [COORD_BITS:0]    left_lower_y_o,
  output logic signed [COORD_BITS:0]    right_upper_x_o,
  output logic signed [COORD_BITS:0]    right_upper_y_o,
  output logic signed [COORD_BITS:0]    left_upper_x_o,
  output logic signed [COORD_BITS:0]    left_upper_y_o,
  output logic                          last_group_o
);
  import mer_pkg::*;

  localparam int RW   = RADIUS_BITS;
  localparam int SQW  = 2 * RW;
  localparam int XW   = RW + 1;
  localparam int YW   = RW + 2;
  localparam int SW   = 3 * RW + 3;
  localparam int DW   = 4 * RW + 4;
  localparam int MW   = 2 * RW + 3;
  localparam int PW   = 2 * MW;
  localparam int OW   = COORD_BITS + 1;
  localparam int SUMW = ((COORD_BITS > YW) ? COORD_BITS : YW) + 1;

  logic signed [COORD_BITS-1:0] cc_q, cr_q;
  logic        [RW-1:0]         rx_q, ry_q;
  logic        [SQW-1:0]        rx2_q, ry2_q;
  logic        [XW-1:0]         x_q;
  logic signed [YW-1:0]         y_q;
  logic signed [SW-1:0]         sx_q, sy_q;
  logic signed [DW-1:0]         dec_q, acc_q;
  logic        [MW-1:0]         ta_q, tb_q;
  logic        [PW-1:0]         prod_q;
  logic                         r2_q, act_q, br_q;

  logic signed [OW-1:0]         rlx_q, rly_q, llx_q, lly_q;
  logic signed [OW-1:0]         rux_q, ruy_q, lux_q, luy_q;
  logic                         last_q;

  logic        [MW-1:0]         mul_a, mul_b;
  logic signed [DW-1:0]         prod_s, rx2_s, ry2_s, sx_s, sy_s;
  logic signed [DW-1:0]         add_t, part_t, dec_next;
  logic signed [SW-1:0]         sx_inc, sy_dec;
  logic signed [YW:0]           ym;
  logic        [YW:0]           ym_abs;
  logic                         dec_neg, dec_pos, step_x, step_y, last, fix;
  logic signed [SUMW-1:0]       cx_e, cy_e, x_e, y_e;
  logic signed [SUMW-1:0]       px, mx, py, my;

  always_comb begin
    prod_s  = $signed(prod_q[DW-1:0]);
    rx2_s   = $signed(DW'(rx2_q));
    ry2_s   = $signed(DW'(ry2_q));
    sx_s    = DW'(sx_q);
    sy_s    = DW'(sy_q);
    sx_inc  = $signed(SW'({ry2_q, 1'b0}));
    sy_dec  = $signed(SW'({rx2_q, 1'b0}));

    ym      = $signed({y_q[YW-1], y_q}) - $signed((YW+1)'(1));
    ym_abs  = ym[YW] ? $unsigned(-ym) : $unsigned(ym);

    dec_neg = dec_q[DW-1];
    dec_pos = !dec_q[DW-1] && (dec_q != '0);
    step_x  = !r2_q || !dec_pos;
    step_y  = r2_q || !dec_neg;
    last    = r2_q && (y_q[YW-1] || (y_q == '0));
    fix     = acc_q[DW-1] && (ry2_q[1:0] != 2'b00);

    add_t   = r2_q ? rx2_s : ry2_s;
    if (br_q) begin
      part_t = r2_q ? -sy_s : sx_s;
    end else begin
      part_t = sx_s - sy_s;
    end
    dec_next = dec_q + part_t + add_t;

    cx_e = SUMW'(cc_q);
    cy_e = SUMW'(cr_q);
    x_e  = $signed(SUMW'(x_q));
    y_e  = SUMW'(y_q);
    px   = cx_e + x_e;
    mx   = cx_e - x_e;
    py   = cy_e + y_e;
    my   = cy_e - y_e;
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RX_RX: begin
        mul_a = MW'(rx_q);
        mul_b = MW'(rx_q);
      end
      MUL_RY_RY: begin
        mul_a = MW'(ry_q);
        mul_b = MW'(ry_q);
      end
      MUL_RX2_RY: begin
        mul_a = MW'(rx2_q);
        mul_b = MW'(ry_q);
      end
      MUL_X_XP1: begin
        mul_a = MW'(x_q);
        mul_b = MW'(x_q) + MW'(1'b1);
      end
      MUL_YM_YM: begin
        mul_a = MW'(ym_abs);
        mul_b = MW'(ym_abs);
      end
      MUL_RY2_TA: begin
        mul_a = MW'(ry2_q);
        mul_b = ta_q;
      end
      MUL_RX2_TB: begin
        mul_a = MW'(rx2_q);
        mul_b = tb_q;
      end
      MUL_RX2_RY2: begin
        mul_a = MW'(rx2_q);
        mul_b = MW'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
    unique case (cmd_i.wb_sel)
      WB_LOAD: begin
        cc_q <= center_x_i;
        cr_q <= center_y_i;
        rx_q <= radius_x_i;
        ry_q <= radius_y_i;
        x_q  <= '0;
        y_q  <= $signed(YW'(radius_y_i));
        sx_q <= '0;
      end
      WB_RX2:  rx2_q <= prod_q[SQW-1:0];
      WB_RY2:  ry2_q <= prod_q[SQW-1:0];
      WB_START: begin
        sy_q  <= $signed({prod_q[SW-2:0], 1'b0});
        dec_q <= ry2_s - prod_s + $signed(DW'(rx2_q >> 2));
      end
      WB_TA:      ta_q  <= prod_q[MW-1:0];
      WB_TB:      tb_q  <= prod_q[MW-1:0];
      WB_ACC_SET: acc_q <= prod_s;
      WB_ACC_ADD: acc_q <= acc_q + prod_s;
      WB_ACC_SUB: acc_q <= acc_q - prod_s + $signed(DW'(ry2_q >> 2));
      WB_SWITCH:  dec_q <= acc_q + $signed(DW'(fix));
      WB_EMIT: begin
        rlx_q  <= $signed(px[OW-1:0]);
        rly_q  <= $signed(py[OW-1:0]);
        llx_q  <= $signed(mx[OW-1:0]);
        lly_q  <= $signed(py[OW-1:0]);
        rux_q  <= $signed(px[OW-1:0]);
        ruy_q  <= $signed(my[OW-1:0]);
        lux_q  <= $signed(mx[OW-1:0]);
        luy_q  <= $signed(my[OW-1:0]);
        last_q <= last;
        br_q   <= r2_q ? dec_pos : dec_neg;
        if (step_x) begin
          x_q  <= x_q + XW'(1'b1);
          sx_q <= sx_q + sx_inc;
        end
        if (step_y) begin
          y_q  <= y_q - $signed(YW'(1));
          sy_q <= sy_q - sy_dec;
        end
      end
      WB_DECIDE: dec_q <= dec_next;
      WB_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q  <= 1'b0;
      act_q <= 1'b0;
    end else begin
      if (cmd_i.wb_sel == WB_LOAD) begin
        r2_q  <= 1'b0;
        act_q <= 1'b1;
      end else if (cmd_i.wb_sel == WB_SWITCH) begin
        r2_q <= 1'b1;
      end else if (cmd_i.wb_sel == WB_EMIT && last) begin
        act_q <= 1'b0;
      end
    end
  end

  assign status_o.active     = act_q;
  assign status_o.switch_due = !r2_q && !(sx_q < sy_q);

  assign right_lower_x_o = rlx_q;
  assign right_lower_y_o = rly_q;
  assign left_lower_x_o  = llx_q;
  assign left_lower_y_o  = lly_q;
  assign right_upper_x_o = rux_q;
  assign right_upper_y_o = ruy_q;
  assign left_upper_x_o  = lux_q;
  assign left_upper_y_o  = luy_q;
  assign last_group_o    = last_q;

endmodule

@@ rtl/core/mer_ctrl.sv @@
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: takes items, runs the multiply sequences for start and region
// change, issues emit and decision update, owns the output valid flag.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  mer_pkg::dp_status_t status_i,
  output mer_pkg::dp_cmd_t    cmd_o
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_SQX,
    S_LD_SQY,
    S_LD_SLOPE,
    S_LD_FIN,
    S_SW_XX,
    S_SW_YY,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SW_D,
    S_SW_FIX,
    S_EMIT,
    S_DEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.mul_sel = MUL_RX_RX;
    cmd_o.wb_sel  = WB_NONE;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CmdStart) begin
            cmd_o.wb_sel = WB_LOAD;
            state_d      = S_LD_SQX;
          end else if (status_i.active) begin
            state_d = status_i.switch_due ? S_SW_XX : S_EMIT;
          end
        end
      end
      S_LD_SQX: begin
        cmd_o.mul_sel = MUL_RX_RX;
        state_d       = S_LD_SQY;
      end
      S_LD_SQY: begin
        cmd_o.mul_sel = MUL_RY_RY;
        cmd_o.wb_sel  = WB_RX2;
        state_d       = S_LD_SLOPE;
      end
      S_LD_SLOPE: begin
        cmd_o.mul_sel = MUL_RX2_RY;
        cmd_o.wb_sel  = WB_RY2;
        state_d       = S_LD_FIN;
      end
      S_LD_FIN: begin
        cmd_o.wb_sel = WB_START;
        state_d      = S_IDLE;
      end
      S_SW_XX: begin
        cmd_o.mul_sel = MUL_X_XP1;
        state_d       = S_SW_YY;
      end
      S_SW_YY: begin
        cmd_o.mul_sel = MUL_YM_YM;
        cmd_o.wb_sel  = WB_TA;
        state_d       = S_SW_A;
      end
      S_SW_A: begin
        cmd_o.mul_sel = MUL_RY2_TA;
        cmd_o.wb_sel  = WB_TB;
        state_d       = S_SW_B;
      end
      S_SW_B: begin
        cmd_o.mul_sel = MUL_RX2_TB;
        cmd_o.wb_sel  = WB_ACC_SET;
        state_d       = S_SW_C;
      end
      S_SW_C: begin
        cmd_o.mul_sel = MUL_RX2_RY2;
        cmd_o.wb_sel  = WB_ACC_ADD;
        state_d       = S_SW_D;
      end
      S_SW_D: begin
        cmd_o.wb_sel = WB_ACC_SUB;
        state_d      = S_SW_FIX;
      end
      S_SW_FIX: begin
        cmd_o.wb_sel = WB_SWITCH;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.wb_sel = WB_EMIT;
          out_valid_d  = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.wb_sel = WB_DECIDE;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/midpoint_ellipse_rasterizer_core.sv @@
// Start item: accepted, then radius squaring and start setup run on the shared multiplier.
// Step item: point group issued when the output slot is free, then the decision update.
// A step entering region two first runs region-change work on the shared multiplier.
// No new item is taken until the emit and decision update of the current step are done.
// Reset is asynchronous, active low: block idle, no ellipse active, no output pending.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Midpoint ellipse outline walker emitting four mirrored points per step.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
  parameter int RADIUS_BITS = mer_pkg::RadiusBitsDef,
  parameter int COORD_BITS  = mer_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_x_i,
  input  logic        [RADIUS_BITS-1:0] radius_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS:0]    right_lower_x_o,
  output logic signed [COORD_BITS:0]    right_lower_y_o,
  output logic signed [COORD_BITS:0]    left_lower_x_o,
  output logic signed [COORD_BITS:0]    left_lower_y_o,
  output logic signed [COORD_BITS:0]    right_upper_x_o,
  output logic signed [COORD_BITS:0]    right_upper_y_o,
  output logic signed [COORD_BITS:0]    left_upper_x_o,
  output logic signed [COORD_BITS:0]    left_upper_y_o,
  output logic                          last_group_o
);
  import mer_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .radius_x_i      (radius_x_i),
    .radius_y_i      (radius_y_i),
    .right_lower_x_o (right_lower_x_o),
    .right_lower_y_o (right_lower_y_o),
    .left_lower_x_o  (left_lower_x_o),
    .left_lower_y_o  (left_lower_y_o),
    .right_upper_x_o (right_upper_x_o),
    .right_upper_y_o (right_upper_y_o),
    .left_upper_x_o  (left_upper_x_o),
    .left_upper_y_o  (left_upper_y_o),
    .last_group_o    (last_group_o)
  );

endmodule

@@ rtl/core/mer_checker.sv @@
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the ellipse rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mer_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic command_i,
  input logic out_valid_o,
  input logic out_stall_i
);
  import mer_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CmdStart) |=> in_stall_o)
    else $error("start setup not holding off input");

  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CmdStart) && !out_valid_o |=> !out_valid_o)
    else $error("start item produced a point group");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("point group issued without decision update pending");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
